[rtl/core/sik_pkg.sv]
package sik_pkg;

    localparam int COORD_W  = 32;
    localparam int DELTA_W  = COORD_W + 1;
    localparam int DIST_W   = 34;
    localparam int SUM_W    = 66;
    localparam int X_W      = 35;

    // distance root: one bit per stage
    localparam int SQRT_STAGES = DIST_W;

    // exponent: x*2^30/s long division, Horner series, then powers of exp(-1)
    localparam int EXP_BITS     = 30;
    localparam int DIV_STAGES   = X_W + EXP_BITS;
    localparam int HORNER_TERMS = 12;
    localparam int HORNER_STAGES = 3 * HORNER_TERMS;
    localparam int POW_STAGES   = 31;
    localparam int EXP_STAGES   = DIV_STAGES + HORNER_STAGES + POW_STAGES;

    localparam logic [30:0] EXP_ONE = 31'h4000_0000;
    localparam logic [28:0] EXP_E1  = 29'd395007542;

    // floor(2^32 / n); estimate is at most one low, fixed after
    localparam logic [32:0] RECIP [1:HORNER_TERMS] = '{
        33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
        33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
        33'd477218588,  33'd429496729,  33'd390451572,  33'd357913941
    };

    // axis scaling: quotient bits of |delta|*|reach|/d
    localparam int QUO_W = 33;

    typedef enum logic [1:0] {
        CFG_CHAIN_LENGTH  = 2'd0,
        CFG_SOFT_DISTANCE = 2'd1,
        CFG_SOFT_ENABLE   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] base;
        logic [2:0][DELTA_W-1:0] delta;      // target - base, signed
        logic [DIST_W-1:0]       root_dist;
        logic                    soft_path;  // softened path taken
        logic                    zero;       // distance is zero
    } item_t;

endpackage

[rtl/core/sik_isqrt.sv]
module sik_isqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_valid,
    input  sik_pkg::item_t                 in_item,
    input  logic [sik_pkg::SUM_W-1:0]      in_sum,
    output logic                           out_valid,
    output sik_pkg::item_t                 out_item,
    output logic [sik_pkg::DIST_W-1:0]     out_root
);

    localparam int N = sik_pkg::SQRT_STAGES;

    typedef struct packed {
        logic [33:0] root;
        logic [67:0] rem;     // sum - root^2
    } sq_t;

    function automatic sq_t sq_step(sq_t s, logic [5:0] pos);
        logic [67:0] trial;
        sq_t         o;
        trial = ({34'd0, s.root} << (pos + 6'd1)) | (68'd1 << {pos, 1'b0});
        o = s;
        if (s.rem >= trial)
        begin
            o.rem  = s.rem - trial;
            o.root = s.root | (34'd1 << pos);
        end
        return o;
    endfunction

    logic [N-1:0]   v_reg;
    sik_pkg::item_t itm_reg [N];
    sq_t            sq_reg  [N];
    sq_t            sq_next [N];

    always_comb
    begin
        sq_next[0] = sq_step({34'd0, 2'b00, in_sum}, 6'(N - 1));
        for (int j = 1; j < N; j++)
        begin
            sq_next[j] = sq_step(sq_reg[j-1], 6'(N - 1 - j));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg     <= sq_next;
            itm_reg[0] <= in_item;
            for (int j = 1; j < N; j++)
            begin
                itm_reg[j] <= itm_reg[j-1];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_item  = itm_reg[N-1];
    assign out_root  = sq_reg[N-1].root;

endmodule

[rtl/core/sik_exp.sv]
module sik_exp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  sik_pkg::item_t              in_item,
    input  logic [sik_pkg::X_W-1:0]     in_x,
    input  logic [30:0]                 soft_distance,
    output logic                        out_valid,
    output sik_pkg::item_t              out_item,
    output logic [30:0]                 out_e
);

    localparam int DS = sik_pkg::DIV_STAGES;
    localparam int HS = sik_pkg::HORNER_STAGES;
    localparam int PS = sik_pkg::POW_STAGES;
    localparam int N  = sik_pkg::EXP_STAGES;

    typedef struct packed {
        logic [34:0] x;
        logic [31:0] rem;
        logic [64:0] q;      // k in [64:30], fraction f in [29:0]
        logic [30:0] p;
        logic [29:0] t;
        logic [29:0] q0;
    } ex_t;

    function automatic ex_t div_step(ex_t s, logic [6:0] j, logic [30:0] dv);
        logic [64:0] dividend;
        logic [32:0] r2;
        logic        qb;
        ex_t         o;
        dividend = {s.x, 30'd0};
        r2 = {s.rem, dividend[7'd64 - j]};
        qb = (r2 >= {2'b00, dv});
        if (qb)
        begin
            r2 = r2 - {2'b00, dv};
        end
        o     = s;
        o.rem = r2[31:0];
        o.q   = {s.q[63:0], qb};
        o.p   = sik_pkg::EXP_ONE;
        return o;
    endfunction

    logic [N-1:0]   v_reg;
    sik_pkg::item_t itm_reg [N];
    ex_t            ex_reg  [N];
    ex_t            ex_next [N];

    always_comb
    begin
        ex_t         s;
        ex_t         init;
        logic [60:0] hp;
        logic [62:0] mp;
        logic [33:0] nq;
        logic [33:0] r;
        logic [29:0] qq;
        logic [59:0] pw;
        int          b;
        init     = '0;
        init.x   = in_x;
        ex_next[0] = div_step(init, 7'd0, soft_distance);
        for (int j = 1; j < DS; j++)
        begin
            ex_next[j] = div_step(ex_reg[j-1], 7'(j), soft_distance);
        end
        // Horner, term n = 12 - i, three stages each
        for (int i = 0; i < sik_pkg::HORNER_TERMS; i++)
        begin
            b = DS + 3 * i;
            s = ex_reg[b-1];
            hp = {31'd0, s.q[29:0]} * {30'd0, s.p};
            s.t = hp[59:30];
            ex_next[b] = s;

            s = ex_reg[b];
            mp = {33'd0, s.t} * {30'd0, sik_pkg::RECIP[sik_pkg::HORNER_TERMS - i]};
            s.q0 = mp[61:32];
            ex_next[b+1] = s;

            s = ex_reg[b+1];
            nq = {4'd0, s.q0} * 34'(sik_pkg::HORNER_TERMS - i);
            r  = {4'd0, s.t} - nq;
            qq = s.q0 + 30'(r >= 34'(sik_pkg::HORNER_TERMS - i));
            s.p = sik_pkg::EXP_ONE - {1'b0, qq};
            ex_next[b+2] = s;
        end
        // k multiplications by exp(-1)
        for (int i = 0; i < PS; i++)
        begin
            b = DS + HS + i;
            s = ex_reg[b-1];
            pw = {29'd0, s.p} * {31'd0, sik_pkg::EXP_E1};
            if (!(|s.q[64:35]) && (5'(i) < s.q[34:30]))
            begin
                s.p = {1'b0, pw[59:30]};
            end
            ex_next[b] = s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_reg     <= ex_next;
            itm_reg[0] <= in_item;
            for (int j = 1; j < N; j++)
            begin
                itm_reg[j] <= itm_reg[j-1];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_item  = itm_reg[N-1];
    // k above 31 flushes to zero
    assign out_e     = (|ex_reg[N-1].q[64:35]) ? 31'd0 : ex_reg[N-1].p;

endmodule

[rtl/core/sik_scale.sv]
module sik_scale (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  sik_pkg::item_t     in_item,
    input  logic [30:0]        in_e,
    input  logic [30:0]        soft_distance,
    input  logic signed [31:0] hard,
    output logic               out_valid,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z
);

    localparam int QB = sik_pkg::QUO_W;
    localparam int NI = QB + 3;        // stages that carry the item
    localparam int N  = NI + 1;

    typedef struct packed {
        logic [33:0] rem;
        logic [32:0] lo;     // dividend bits still to shift in
        logic [32:0] q;
        logic        neg;
    } ax_t;

    logic [N-1:0]       v_reg;
    sik_pkg::item_t     itm_reg [NI];
    logic [31:0]        add_reg, add_next;
    logic [32:0]        rm_reg, rm_next;
    logic               negr_reg, negr_next;
    ax_t [2:0]          ax_reg  [QB+1];
    ax_t [2:0]          ax_next [QB+1];
    logic [2:0][31:0]   res_reg, res_next;

    // reach = h + s*(1 - e)
    always_comb
    begin
        logic [61:0] sp;
        logic [33:0] reach;
        sp = {31'd0, soft_distance} * {31'd0, 31'(sik_pkg::EXP_ONE - in_e)};
        add_next = sp[61:30];
        reach = {{2{hard[31]}}, hard} + {2'b00, add_reg};
        negr_next = reach[33];
        rm_next = reach[33] ? 33'(-reach) : reach[32:0];
    end

    // |delta| * |reach|, then long division by d
    always_comb
    begin
        logic [32:0] mag;
        logic [65:0] pr;
        logic [34:0] r2;
        logic        qb;
        ax_t         a;
        for (int k = 0; k < 3; k++)
        begin
            mag = itm_reg[1].delta[k][32] ? 33'(-itm_reg[1].delta[k])
                                          : itm_reg[1].delta[k];
            pr = {33'd0, mag} * {33'd0, rm_reg};
            ax_next[0][k].rem = {1'b0, pr[65:33]};
            ax_next[0][k].lo  = pr[32:0];
            ax_next[0][k].q   = '0;
            ax_next[0][k].neg = itm_reg[1].delta[k][32] ^ negr_reg;
        end
        for (int j = 1; j <= QB; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a  = ax_reg[j-1][k];
                r2 = {a.rem, a.lo[32]};
                qb = (r2 >= {1'b0, itm_reg[j+1].root_dist});
                if (qb)
                begin
                    r2 = r2 - {1'b0, itm_reg[j+1].root_dist};
                end
                a.rem = r2[33:0];
                a.lo  = {a.lo[31:0], 1'b0};
                a.q   = {a.q[31:0], qb};
                ax_next[j][k] = a;
            end
        end
    end

    // apply sign, saturate, choose path
    always_comb
    begin
        logic [34:0] sum;
        logic [34:0] off;
        ax_t         a;
        for (int k = 0; k < 3; k++)
        begin
            a   = ax_reg[QB][k];
            off = a.neg ? 35'(-{2'b00, a.q}) : {2'b00, a.q};
            sum = {{3{itm_reg[NI-1].base[k][31]}}, itm_reg[NI-1].base[k]} + off;
            if (!itm_reg[NI-1].soft_path)
            begin
                res_next[k] = itm_reg[NI-1].base[k] + itm_reg[NI-1].delta[k][31:0];
            end
            else if (itm_reg[NI-1].zero)
            begin
                res_next[k] = itm_reg[NI-1].base[k];
            end
            else if (!sum[34] && (|sum[33:31]))
            begin
                res_next[k] = 32'h7fff_ffff;
            end
            else if (sum[34] && !(&sum[33:31]))
            begin
                res_next[k] = 32'h8000_0000;
            end
            else
            begin
                res_next[k] = sum[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            add_reg    <= add_next;
            rm_reg     <= rm_next;
            negr_reg   <= negr_next;
            ax_reg     <= ax_next;
            res_reg    <= res_next;
            itm_reg[0] <= in_item;
            for (int j = 1; j < NI; j++)
            begin
                itm_reg[j] <= itm_reg[j-1];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_x     = res_reg[0];
    assign out_y     = res_reg[1];
    assign out_z     = res_reg[2];

endmodule

[rtl/core/soft_ik_end_position_core.sv]
// Soft IK end position, exponential falloff.
// Input channel (in_valid / in_stall): one item is a base point and a control
// point, three signed Q16.16 coordinates each. Output channel (out_valid /
// out_stall): the softened end point, saturated to 32 bits, one per item.
// Config port (cfg_valid / cfg_ready / cfg_index / cfg_data): chain length,
// soft distance, soft enable. Always ready; write only while the pipe is empty.
// Stages: 3 front stages, 34 root stages (one bit each), 1 compare stage,
// 65 long-division stages for (d-h)*2^30/s, 36 Horner stages (three per
// series term), 31 exp(-1) power stages, 37 scaling stages (33 of them the
// per-axis quotient). Throughput is one item per cycle while no finished
// result is held. All stages move together on one advance
// signal: a stalled result freezes the whole pipe, in_stall rises with it,
// and nothing is dropped or repeated. Reset clears the valid bits and the
// config registers (all zero: soft mode off, control point passes through).
module soft_ik_end_position_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] base_x,
    input  logic signed [31:0] base_y,
    input  logic signed [31:0] base_z,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z
);

    logic [30:0] chain_length_reg;
    logic [30:0] soft_distance_reg;
    logic        soft_enable_reg;
    logic        adv;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_length_reg  <= '0;
            soft_distance_reg <= '0;
            soft_enable_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sik_pkg::CFG_CHAIN_LENGTH:  chain_length_reg  <= cfg_data[30:0];
                sik_pkg::CFG_SOFT_DISTANCE: soft_distance_reg <= cfg_data[30:0];
                sik_pkg::CFG_SOFT_ENABLE:   soft_enable_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // whole pipe moves unless a finished result is held
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // hard distance h = L - s, signed
    logic signed [31:0] hard;
    assign hard = {1'b0, chain_length_reg} - {1'b0, soft_distance_reg};

    // stage 0: deltas
    logic                        v0_reg;
    sik_pkg::item_t              itm0_reg, itm0_next;
    logic [2:0][31:0]            tgt;

    always_comb
    begin
        tgt = {target_z, target_y, target_x};
        itm0_next      = '0;
        itm0_next.base = {base_z, base_y, base_x};
        for (int k = 0; k < 3; k++)
        begin
            itm0_next.delta[k] = {tgt[k][31], tgt[k]}
                               - {itm0_next.base[k][31], itm0_next.base[k]};
        end
    end

    // stage 1: squares
    logic                        v1_reg;
    sik_pkg::item_t              itm1_reg;
    logic [2:0][65:0]            sq_reg, sq_next;

    always_comb
    begin
        logic [32:0] mag;
        for (int k = 0; k < 3; k++)
        begin
            mag = itm0_reg.delta[k][32] ? 33'(-itm0_reg.delta[k]) : itm0_reg.delta[k];
            sq_next[k] = {33'd0, mag} * {33'd0, mag};
        end
    end

    // stage 2: sum of squares (below 2^66)
    logic                        v2_reg;
    sik_pkg::item_t              itm2_reg;
    logic [65:0]                 sum_reg, sum_next;

    assign sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            itm0_reg <= itm0_next;
            itm1_reg <= itm0_reg;
            sq_reg   <= sq_next;
            itm2_reg <= itm1_reg;
            sum_reg  <= sum_next;
        end
    end

    // distance
    logic           sq_valid;
    sik_pkg::item_t sq_item;
    logic [33:0]    dist_root;

    sik_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v2_reg),
        .in_item   (itm2_reg),
        .in_sum    (sum_reg),
        .out_valid (sq_valid),
        .out_item  (sq_item),
        .out_root  (dist_root)
    );

    // stage 3: soft decision and x = d - h
    logic           v3_reg;
    sik_pkg::item_t itm3_reg, itm3_next;
    logic [34:0]    x_reg, x_next;

    always_comb
    begin
        logic [35:0] d36;
        logic [35:0] h36;
        logic [35:0] diff;
        d36  = {2'b00, dist_root};
        h36  = {{4{hard[31]}}, hard};
        diff = d36 - h36;
        itm3_next           = sq_item;
        itm3_next.root_dist = dist_root;
        itm3_next.zero      = (dist_root == '0);
        itm3_next.soft_path = soft_enable_reg && (|soft_distance_reg)
                           && ($signed(d36) >= $signed(h36));
        x_next = diff[34:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            itm3_reg <= itm3_next;
            x_reg    <= x_next;
        end
    end

    // exp(-(d-h)/s) in Q1.30
    logic           ex_valid;
    sik_pkg::item_t ex_item;
    logic [30:0]    e;

    sik_exp u_exp (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_valid      (v3_reg),
        .in_item       (itm3_reg),
        .in_x          (x_reg),
        .soft_distance (soft_distance_reg),
        .out_valid     (ex_valid),
        .out_item      (ex_item),
        .out_e         (e)
    );

    // reach, per-axis scaling, output register
    sik_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_valid      (ex_valid),
        .in_item       (ex_item),
        .in_e          (e),
        .soft_distance (soft_distance_reg),
        .hard          (hard),
        .out_valid     (out_valid),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_z         (out_z)
    );

endmodule
